// ----- design/stk_pkg.sv -----
// Shared types and codes for the stack with delete-by-value.
// No dependencies. Used by stk_ctrl and stack_with_value_delete_unit.
package stk_pkg;

  // operation codes carried in the mode field
  typedef enum logic [2:0] {
    OP_PUSH      = 3'd0,
    OP_POP       = 3'd1,
    OP_DEL_FIRST = 3'd2,
    OP_DEL_ALL   = 3'd3,
    OP_CLEAR     = 3'd4
  } stk_op_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TOPRD,
    ST_RESP
  } stk_state_e;

  // input beat
  typedef struct packed {
    logic        [2:0]  mode;
    logic signed [31:0] value;
  } stk_in_t;

  // result beat
  typedef struct packed {
    logic signed [31:0] top_value;
    logic               not_empty;
    logic        [4:0]  entry_count;
    logic        [4:0]  removed_count;
    logic               push_refused;
  } stk_out_t;

endpackage

// ----- design/stk_mem.sv -----
// Entry storage: one write port, one read port, registered read data.
// No package dependencies.
module stk_mem #(
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [Depth];
  logic [31:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/stk_ctrl.sv -----
// Operation sequencer: push/pop/clear, compaction scan for deletes, result register.
// Depends on stk_pkg; drives the ports of stk_mem.
module stk_ctrl
  import stk_pkg::*;
#(
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CW = $clog2(Depth + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  stk_in_t       in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output stk_out_t      out_data_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [31:0]   mem_wdata_o,
  output logic          mem_re_o,
  output logic [AW-1:0] mem_raddr_o,
  input  logic [31:0]   mem_rdata_i
);

  stk_state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [31:0]   top_q, top_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [CW-1:0] wr_q, wr_d;
  logic          found_q, found_d;
  stk_op_e       mode_q, mode_d;
  logic [31:0]   word_q, word_d;
  logic [CW-1:0] removed_q, removed_d;
  logic          refused_q, refused_d;
  logic          out_valid_q, out_valid_d;
  stk_out_t      out_data_q;

  stk_op_e       in_op;
  logic          has_room;
  logic [CW-1:0] count_m1, count_m2;
  logic          scan_drop, scan_last, slot_free;
  logic [CW-1:0] wr_next;
  logic [CW+4:0] count_ext, removed_ext;

  assign in_op     = stk_op_e'(in_data_i.mode);
  assign has_room  = (count_q < CW'(Depth));
  assign count_m1  = count_q - CW'(1);
  assign count_m2  = count_q - CW'(2);
  assign slot_free = !out_valid_q || out_ready_i;

  // compaction scan: drop a match (only the first one for delete-first)
  assign scan_drop = (mem_rdata_i == word_q) && ((mode_q == OP_DEL_ALL) || !found_q);
  assign scan_last = (CW'(rd_q) == count_m1);
  assign wr_next   = scan_drop ? wr_q : wr_q + CW'(1);

  assign in_ready_o = (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RESP;
          case (in_op)
            OP_POP: begin
              if (count_q > CW'(1)) state_d = ST_TOPRD;
            end
            OP_DEL_FIRST, OP_DEL_ALL: begin
              if (count_q != '0) state_d = ST_SCAN;
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_last) state_d = ST_RESP;
      end
      ST_TOPRD: state_d = ST_RESP;
      ST_RESP: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    count_d     = count_q;
    top_d       = top_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    found_d     = found_q;
    mode_d      = mode_q;
    word_d      = word_q;
    removed_d   = removed_q;
    refused_d   = refused_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d    = in_op;
          word_d    = in_data_i.value;
          removed_d = '0;
          refused_d = 1'b0;
          case (in_op)
            OP_PUSH: begin
              if (has_room) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = count_q[AW-1:0];
                mem_wdata_o = in_data_i.value;
                count_d     = count_q + CW'(1);
                top_d       = in_data_i.value;
              end else begin
                refused_d = 1'b1;
              end
            end
            OP_POP: begin
              if (count_q != '0) begin
                count_d   = count_m1;
                removed_d = CW'(1);
                if (count_q > CW'(1)) begin
                  mem_re_o    = 1'b1;
                  mem_raddr_o = count_m2[AW-1:0];
                end else begin
                  top_d = '0;
                end
              end
            end
            OP_DEL_FIRST, OP_DEL_ALL: begin
              if (count_q != '0) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                rd_d        = '0;
                wr_d        = '0;
                found_d     = 1'b0;
                top_d       = '0;
              end
            end
            OP_CLEAR: begin
              removed_d = count_q;
              count_d   = '0;
              top_d     = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // read data belongs to slot rd_q; kept words move down to slot wr_q
        if (scan_drop) begin
          found_d = 1'b1;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = wr_q[AW-1:0];
          mem_wdata_o = mem_rdata_i;
          top_d       = mem_rdata_i;
        end
        wr_d = wr_next;
        if (scan_last) begin
          count_d   = wr_next;
          removed_d = count_q - wr_next;
        end else begin
          rd_d        = rd_q + 1'b1;
          mem_re_o    = 1'b1;
          mem_raddr_o = rd_q + 1'b1;
        end
      end
      ST_TOPRD: top_d = mem_rdata_i;
      default: ;
    endcase
  end

  // result register
  assign count_ext   = {5'd0, count_q};
  assign removed_ext = {5'd0, removed_q};
  assign out_valid_d = ((state_q == ST_RESP) && slot_free) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_RESP) && slot_free) begin
      out_data_q.top_value     <= top_q;
      out_data_q.not_empty     <= (count_q != '0);
      out_data_q.entry_count   <= count_ext[4:0];
      out_data_q.removed_count <= removed_ext[4:0];
      out_data_q.push_refused  <= refused_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
    end
  end

  // per-item working registers
  always_ff @(posedge clk_i) begin
    rd_q      <= rd_d;
    wr_q      <= wr_d;
    found_q   <= found_d;
    mode_q    <= mode_d;
    word_q    <= word_d;
    removed_q <= removed_d;
    refused_q <= refused_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- design/stack_with_value_delete_unit.sv -----
// LIFO stack with delete-by-value. Push, clear, refused push, idle codes and a pop that
// leaves the stack empty go straight to the result state; other pops first read the new top.
// Deletes scan the entry memory one slot a cycle, over every held entry, up to STACK_DEPTH.
// One item in flight: the next beat is taken once the result is registered, which waits
// while the result side holds back an earlier result.
// Reset (async, active low) empties the stack; entry memory is not cleared. Uses stk_pkg, stk_mem, stk_ctrl.
module stack_with_value_delete_unit
  import stk_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  stk_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output stk_out_t out_data_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  // sequencer
  stk_ctrl #(
    .Depth(STACK_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // entry storage
  stk_mem #(
    .Depth(STACK_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ----- verif/tb.sv -----
// Self-checking bench for stack_with_value_delete_unit: directed and random stack traffic,
// each result beat compared against an in-bench model of the stack.
// Depends on stk_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb;
  import stk_pkg::*;

  localparam int unsigned STACK_DEPTH = 16;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int unsigned DRAIN_CYCLES = STACK_DEPTH + 6;
  localparam int unsigned RANDOM_BEATS = 200;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  stk_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  stk_out_t out_data_o;

  // model of the stack, slot 0 at the bottom
  logic signed [31:0] model_words [STACK_DEPTH];
  int unsigned        model_depth = 0;
  stk_out_t           pending_results [$];
  int unsigned        mismatch_count = 0;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;
  logic signed [31:0] value_pool [4];

  stack_with_value_delete_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // apply one operation to the model and return the result it should report
  function automatic stk_out_t stack_apply(stk_in_t beat);
    stk_out_t    res;
    int unsigned removed;
    int unsigned kept;
    int unsigned k;
    bit          found;
    res = '0;
    removed = 0;
    kept = 0;
    found = 1'b0;
    case (beat.mode)
      OP_PUSH: begin
        if (model_depth < STACK_DEPTH) begin
          model_words[model_depth] = beat.value;
          model_depth++;
        end else begin
          res.push_refused = 1'b1;
        end
      end
      OP_POP: begin
        if (model_depth > 0) begin
          model_depth--;
          removed = 1;
        end
      end
      OP_DEL_FIRST: begin
        // oldest match goes, entries above it slide down
        for (k = 0; k < model_depth; k++) begin
          if (found) model_words[k - 1] = model_words[k];
          else if (model_words[k] == beat.value) found = 1'b1;
        end
        if (found) begin
          model_depth--;
          removed = 1;
        end
      end
      OP_DEL_ALL: begin
        for (k = 0; k < model_depth; k++) begin
          if (model_words[k] != beat.value) begin
            model_words[kept] = model_words[k];
            kept++;
          end
        end
        removed = model_depth - kept;
        model_depth = kept;
      end
      OP_CLEAR: begin
        removed = model_depth;
        model_depth = 0;
      end
      default: ;
    endcase
    res.top_value     = (model_depth > 0) ? model_words[model_depth - 1] : '0;
    res.not_empty     = (model_depth > 0);
    res.entry_count   = model_depth[4:0];
    res.removed_count = removed[4:0];
    return res;
  endfunction

  // result side: random back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // result side: compare each accepted beat with the oldest prediction
  always @(posedge clk_i) begin
    stk_out_t exp_res;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction pending");
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data_o.top_value !== exp_res.top_value) begin
          $error("top_value: expected %0d, got %0d", exp_res.top_value, out_data_o.top_value);
          mismatch_count++;
        end
        if (out_data_o.not_empty !== exp_res.not_empty) begin
          $error("not_empty: expected %0d, got %0d", exp_res.not_empty, out_data_o.not_empty);
          mismatch_count++;
        end
        if (out_data_o.entry_count !== exp_res.entry_count) begin
          $error("entry_count: expected %0d, got %0d",
                 exp_res.entry_count, out_data_o.entry_count);
          mismatch_count++;
        end
        if (out_data_o.removed_count !== exp_res.removed_count) begin
          $error("removed_count: expected %0d, got %0d",
                 exp_res.removed_count, out_data_o.removed_count);
          mismatch_count++;
        end
        if (out_data_o.push_refused !== exp_res.push_refused) begin
          $error("push_refused: expected %0d, got %0d",
                 exp_res.push_refused, out_data_o.push_refused);
          mismatch_count++;
        end
      end
    end
  end

  // drive one beat, wait for it to be taken, then maybe leave a gap
  task automatic send_op(logic [2:0] mode, logic signed [31:0] value);
    stk_in_t beat;
    beat.mode = mode;
    beat.value = value;
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(stack_apply(beat));
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // hold off until every predicted result is back, then let the unit settle
  task automatic wait_for_results;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // fill to the limit with extremes and repeats, then a refused push
  task automatic test_fill_and_refuse;
    send_op(OP_PUSH, 32'sh8000_0000);
    send_op(OP_PUSH, 32'sh7fff_ffff);
    send_op(OP_PUSH, 32'sd0);
    send_op(OP_PUSH, -32'sd1);
    for (int unsigned i = 4; i < STACK_DEPTH; i++) begin
      send_op(OP_PUSH, (i % 3 == 0) ? 32'sd0 : 32'sd100 + i);
    end
    send_op(OP_PUSH, 32'sd55);
  endtask

  // delete the oldest of several copies, all copies, a word not held, and the bottom word
  task automatic test_deletes;
    send_op(OP_DEL_FIRST, 32'sd0);
    send_op(OP_DEL_ALL, 32'sd0);
    send_op(OP_DEL_FIRST, 32'sd12345);
    send_op(OP_DEL_ALL, 32'sh8000_0000);
  endtask

  // pop, spare codes, clear, then pop, deletes and clear on an empty stack
  task automatic test_pop_clear_empty;
    send_op(OP_POP, 32'sd0);
    for (logic [3:0] m = 4'(MODE_SPARE_LO); m <= 4'(MODE_SPARE_HI); m++) begin
      send_op(m[2:0], -32'sd1);
    end
    send_op(OP_CLEAR, 32'sd0);
    send_op(OP_POP, 32'sd0);
    send_op(OP_DEL_FIRST, 32'sd0);
    send_op(OP_DEL_ALL, 32'sd0);
    send_op(OP_CLEAR, 32'sd0);
  endtask

  // random traffic; words mostly from a small set so deletes find matches
  task automatic test_random_traffic(int unsigned beats);
    int unsigned push_pct;
    int unsigned r;
    logic [2:0]  mode;
    logic signed [31:0] value;
    push_pct = 70;
    for (int unsigned k = 0; k < 4; k++) begin
      value_pool[k] = ($urandom_range(0, 3) == 0) ? 32'sh8000_0000 : $urandom;
    end
    for (int unsigned i = 0; i < beats; i++) begin
      // alternate filling and draining bursts to visit full and empty
      if (i % 24 == 0) push_pct = (push_pct == 70) ? 20 : 70;
      r = $urandom_range(0, 99);
      if (r < push_pct) mode = OP_PUSH;
      else if (r < push_pct + 10) mode = OP_POP;
      else if (r < push_pct + 18) mode = OP_DEL_FIRST;
      else if (r < push_pct + 25) mode = OP_DEL_ALL;
      else if (r < push_pct + 27) mode = OP_CLEAR;
      else if (r < push_pct + 29) mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      else mode = OP_POP;
      value = ($urandom_range(0, 3) == 0) ? $urandom : value_pool[$urandom_range(0, 3)];
      send_op(mode, value);
    end
    wait_for_results();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 27;
    recv_idle_pct = 78;
    test_fill_and_refuse();
    wait_for_results();
    test_deletes();
    test_pop_clear_empty();
    test_random_traffic(RANDOM_BEATS);

    send_idle_pct = 78;
    recv_idle_pct = 27;
    test_random_traffic(RANDOM_BEATS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(RANDOM_BEATS);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/stk_pkg.sv
design/stk_mem.sv
design/stk_ctrl.sv
design/stack_with_value_delete_unit.sv
verif/tb.sv
